// ===== rtl/tslnf_pkg.sv =====
// ----------------------------------------------------------------------------
// tslnf_pkg
// Shared types, register indexes and character codes for the line number
// formatter.
// ----------------------------------------------------------------------------
package tslnf_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 2;

  localparam logic [CfgIdxW-1:0] REG_NUMBER_MODE      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SQUEEZE_BLANK    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SHOW_ENDS        = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHOW_TABS        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHOW_NONPRINTING = 3'd4;

  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONBLANK = 2'd2;

  // Line numbers are right-aligned in this many places.
  localparam int PAD_WIDTH = 6;
  // Longest escape sequence for one byte.
  localparam int ESC_MAX   = 4;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_CTRL_OFS = 8'h40;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_M        = 8'h4D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_META_LO  = 8'h80;
  localparam logic [7:0] CH_META_HI  = 8'hA0;
  localparam logic [7:0] CH_FF       = 8'hFF;

  // One job for the output sequencer: optional number prefix, then the
  // escape sequence seq[0..last_idx].
  typedef struct packed {
    logic                    num_en;
    logic [ESC_MAX-1:0][7:0] seq;
    logic [1:0]              last_idx;
  } job_t;

  // Expands one byte into the visible form that the options ask for.
  function automatic job_t expand(logic [7:0] c, logic st, logic se, logic np);
    job_t e;
    e          = '0;
    e.seq[0]   = c;
    e.last_idx = 2'd0;
    if (st && c == CH_TAB) begin
      e.seq[0] = CH_CARET; e.seq[1] = CH_I; e.last_idx = 2'd1;
    end else if (se && c == CH_NL) begin
      e.seq[0] = CH_DOLLAR; e.seq[1] = CH_NL; e.last_idx = 2'd1;
    end else if (np && c < CH_SPACE && c != CH_TAB && c != CH_NL) begin
      e.seq[0] = CH_CARET; e.seq[1] = c + CH_CTRL_OFS; e.last_idx = 2'd1;
    end else if (np && c == CH_DEL) begin
      e.seq[0] = CH_CARET; e.seq[1] = CH_QMARK; e.last_idx = 2'd1;
    end else if (np && c >= CH_META_LO && c < CH_META_HI) begin
      e.seq[0] = CH_M; e.seq[1] = CH_DASH; e.seq[2] = CH_CARET;
      e.seq[3] = c - CH_CTRL_OFS; e.last_idx = 2'd3;
    end else if (np && c == CH_FF) begin
      e.seq[0] = CH_M; e.seq[1] = CH_DASH; e.seq[2] = CH_CARET;
      e.seq[3] = CH_QMARK; e.last_idx = 2'd3;
    end else begin
      e.seq[0] = c;
    end
    return e;
  endfunction

endpackage

// ===== rtl/tslnf_emit.sv =====
// ----------------------------------------------------------------------------
// tslnf_emit
// Output sequencer: holds one job and sends its beats, one per cycle while
// out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module tslnf_emit #(
  parameter int NUMBER_DIGITS = 7
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  output logic                                   load_ready,
  input  tslnf_pkg::job_t                        job,
  input  logic [NUMBER_DIGITS-1:0][3:0]          digits,
  input  logic [$clog2(NUMBER_DIGITS+1)-1:0]     ndig,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output tslnf_pkg::out_t                        out_beat
);
  import tslnf_pkg::*;

  localparam int KW     = $clog2(NUMBER_DIGITS + 1);
  localparam int DIW    = $clog2(NUMBER_DIGITS);
  localparam int PadMax = (NUMBER_DIGITS > PAD_WIDTH) ? NUMBER_DIGITS : PAD_WIDTH;
  localparam int NLW    = $clog2(PadMax + 2);

  logic                         job_v;
  job_t                         job_r;
  logic [NUMBER_DIGITS-1:0][3:0] dig_r;
  logic [KW-1:0]                k_r;
  logic [NLW-1:0]               num_left;
  logic [1:0]                   esc_idx;

  logic           advance;
  logic           in_num;
  logic           beat_last;
  logic           done_now;
  logic [NLW-1:0] idx;
  logic [NLW-1:0] prefix_len;
  out_t           beat;

  always_comb begin
    advance   = job_v && (!out_valid || out_ready);
    in_num    = (num_left != '0);
    idx       = num_left - NLW'(2);
    beat_last = !in_num && (esc_idx == job_r.last_idx);
    done_now  = advance && beat_last;
    beat.last_of_run = beat_last;
    if (!in_num) begin
      beat.out_byte = job_r.seq[esc_idx];
    end else if (num_left == NLW'(1)) begin
      beat.out_byte = CH_TAB;
    end else if (idx >= NLW'(k_r)) begin
      beat.out_byte = CH_SPACE;
    end else begin
      beat.out_byte = CH_ZERO + {4'd0, dig_r[idx[DIW-1:0]]};
    end
    // Prefix is the padded number plus its tab.
    if (NLW'(ndig) > NLW'(PAD_WIDTH)) begin
      prefix_len = NLW'(ndig) + NLW'(1);
    end else begin
      prefix_len = NLW'(PAD_WIDTH + 1);
    end
  end

  assign load_ready = !job_v || done_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        job_v <= 1'b1;
      end else if (done_now) begin
        job_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat <= beat;
    end
    // A new job replaces the old one in the cycle its last beat goes out.
    if (load) begin
      job_r    <= job;
      dig_r    <= digits;
      k_r      <= ndig;
      num_left <= job.num_en ? prefix_len : '0;
      esc_idx  <= 2'd0;
    end else if (advance) begin
      if (in_num) begin
        num_left <= num_left - NLW'(1);
      end else begin
        esc_idx <= esc_idx + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/text_stream_line_number_formatter.sv =====
// ----------------------------------------------------------------------------
// text_stream_line_number_formatter
// Byte-stream text formatter with line numbering, blank line squeezing and
// visible tabs, line ends and non-printing bytes.
// ----------------------------------------------------------------------------
// An accepted input beat's first output beat passes through the job register
// and then the output register. Throughput: one output beat per cycle unless
// out_ready stalls; a byte that expands to more than one beat holds in_ready
// low until its last beat is sent, so plain text flows at one byte per cycle.
// The output sequencer, which sends one beat a cycle, sets that rate.
// Reset (synchronous): options clear, the line number returns to one, the
// newline run to one, and both stages empty.
// ----------------------------------------------------------------------------
module text_stream_line_number_formatter #(
  parameter int NUMBER_DIGITS = 7
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tslnf_pkg::CfgIdxW-1:0]      cfg_addr,
  input  logic [tslnf_pkg::CfgDataW-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tslnf_pkg::in_t                     in_beat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tslnf_pkg::out_t                    out_beat
);
  import tslnf_pkg::*;

  localparam int KW = $clog2(NUMBER_DIGITS + 1);

  // Option registers.
  logic [1:0] number_mode;
  logic       squeeze_blank;
  logic       show_ends;
  logic       show_tabs;
  logic       show_nonprinting;

  // The line number is kept in BCD, one nibble per decimal digit, so that
  // printing it is a plain digit select and needs no binary conversion.
  logic [NUMBER_DIGITS-1:0][3:0] line_number;
  logic [1:0]                    newline_run;

  logic [NUMBER_DIGITS-1:0][3:0] num_one;
  logic [NUMBER_DIGITS-1:0][3:0] num_cur;
  logic [NUMBER_DIGITS-1:0][3:0] num_inc;
  logic [NUMBER_DIGITS-1:0][3:0] line_number_next;
  logic [1:0]                    run_cur;
  logic [1:0]                    newline_run_next;
  logic                          carry;
  logic                          at_cap;
  logic [KW-1:0]                 ndig;
  logic                          is_nl;
  logic                          drop;
  logic                          numbered;
  logic                          accept;
  logic                          load;
  logic                          load_ready;
  job_t                          job;

  always_comb begin
    num_one    = '0;
    num_one[0] = 4'd1;

    // A new file restarts the counter and the run before the byte counts.
    num_cur = in_beat.file_start ? num_one : line_number;
    run_cur = in_beat.file_start ? 2'd1 : newline_run;
    is_nl   = (in_beat.data_byte == CH_NL);

    // With squeezing, a third or later newline in a row vanishes and leaves
    // all state as it was.
    drop = squeeze_blank && run_cur[1] && is_nl;

    // Any byte after a newline (or at file start) begins a line. Non-blank
    // numbering skips lines that are just a newline; mode three numbers none.
    numbered = (run_cur != 2'd0) &&
               ((number_mode == NUM_ALL) || (number_mode == NUM_NONBLANK && !is_nl));

    // BCD increment, holding at all nines.
    carry  = 1'b1;
    at_cap = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      at_cap = at_cap && (num_cur[i] == 4'd9);
      if (carry && num_cur[i] == 4'd9) begin
        num_inc[i] = 4'd0;
      end else if (carry) begin
        num_inc[i] = num_cur[i] + 4'd1;
        carry      = 1'b0;
      end else begin
        num_inc[i] = num_cur[i];
      end
    end
    line_number_next = (numbered && !at_cap) ? num_inc : num_cur;

    // Count of significant digits, at least one.
    ndig = KW'(1);
    for (int i = 1; i < NUMBER_DIGITS; i++) begin
      if (num_cur[i] != 4'd0) begin
        ndig = KW'(i + 1);
      end
    end

    if (!is_nl) begin
      newline_run_next = 2'd0;
    end else if (run_cur[1]) begin
      newline_run_next = 2'd2;
    end else begin
      newline_run_next = run_cur + 2'd1;
    end

    job        = expand(in_beat.data_byte, show_tabs, show_ends, show_nonprinting);
    job.num_en = numbered;
  end

  // The front end takes a byte whenever the sequencer can hold a new job,
  // which includes the cycle in which it sends the last beat of the old one.
  assign in_ready = load_ready;
  assign accept   = in_valid && in_ready;
  assign load     = accept && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode      <= 2'd0;
      squeeze_blank    <= 1'b0;
      show_ends        <= 1'b0;
      show_tabs        <= 1'b0;
      show_nonprinting <= 1'b0;
      line_number      <= num_one;
      newline_run      <= 2'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_NUMBER_MODE:      number_mode      <= cfg_wdata;
          REG_SQUEEZE_BLANK:    squeeze_blank    <= cfg_wdata[0];
          REG_SHOW_ENDS:        show_ends        <= cfg_wdata[0];
          REG_SHOW_TABS:        show_tabs        <= cfg_wdata[0];
          REG_SHOW_NONPRINTING: show_nonprinting <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (load) begin
        line_number <= line_number_next;
        newline_run <= newline_run_next;
      end
    end
  end

  // Output sequencer: number prefix digits, tab, then the escape bytes.
  tslnf_emit #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_ready (load_ready),
    .job        (job),
    .digits     (num_cur),
    .ndig       (ndig),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

endmodule

// ===== rtl/tslnf_checker.sv =====
// ----------------------------------------------------------------------------
// tslnf_checker
// Port-level checks for the line number formatter, bound to the top level.
// ----------------------------------------------------------------------------
module tslnf_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input tslnf_pkg::out_t out_beat
);
  import tslnf_pkg::*;

  // Accepted bytes minus delivered last beats. Dropped newlines never finish,
  // so this only ever overstates the work in flight; it sticks once full.
  logic [7:0] pending;
  logic       acc;
  logic       fin;

  assign acc = in_valid && in_ready;
  assign fin = out_valid && out_ready && out_beat.last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 8'd0;
    end else if (pending != 8'hFF) begin
      pending <= pending + {7'd0, acc} - {7'd0, fin};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("output beat changed while stalled");

  a_no_orphan_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("output beat with no byte in flight");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("block not empty after reset");

  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> pending != 8'd0)
    else $error("input stalled with nothing in flight");

endmodule

bind text_stream_line_number_formatter tslnf_checker u_tslnf_checker (.*);

// ===== tb/tslnf_output_checker.sv =====
// ----------------------------------------------------------------------------
// tslnf_output_checker
// Watches the option port and both beat channels of the line number
// formatter, predicts the formatted bytes of every accepted input beat and
// compares each accepted output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tslnf_output_checker #(
  parameter int NUMBER_DIGITS = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tslnf_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [tslnf_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  tslnf_pkg::in_t                 in_beat,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  tslnf_pkg::out_t                out_beat,
  output int                             mismatches,
  output int                             beats_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import tslnf_pkg::*;

  logic [1:0]      num_mode;
  logic            squeeze;
  logic            ends_on;
  logic            tabs_on;
  logic            nonprint_on;
  longint unsigned line_no;
  logic [1:0]      nl_run;
  out_t            owed_beats[$];
  int              fail_tally = 0;

  function automatic longint unsigned line_limit();
    longint unsigned m;
    m = 1;
    repeat (NUMBER_DIGITS) m = m * 10;
    return m - 1;
  endfunction

  // Formats one input byte and queues the beats it should produce.
  task automatic format_byte(input logic [7:0] c, input logic fs);
    logic [7:0]      text[$];
    longint unsigned v;
    logic            at_line_start;
    out_t            beat;
    if (fs) begin
      line_no = 1;
      nl_run  = 2'd1;
    end
    // A third or later newline in a row vanishes without touching state.
    if (squeeze && nl_run >= 2'd2 && c == CH_NL) return;

    at_line_start = (nl_run != 2'd0);
    if ((num_mode == NUM_ALL && at_line_start) ||
        (num_mode == NUM_NONBLANK && at_line_start && c != CH_NL)) begin
      v = line_no;
      do begin
        text.push_front(CH_ZERO + 8'(v % 10));
        v = v / 10;
      end while (v != 0);
      while (text.size() < PAD_WIDTH) text.push_front(CH_SPACE);
      text.push_back(CH_TAB);
      if (line_no < line_limit()) line_no++;
    end

    if (tabs_on && c == CH_TAB) begin
      text.push_back(CH_CARET); text.push_back(CH_I);
    end else if (ends_on && c == CH_NL) begin
      text.push_back(CH_DOLLAR); text.push_back(CH_NL);
    end else if (nonprint_on && c < CH_SPACE && c != CH_TAB && c != CH_NL) begin
      text.push_back(CH_CARET); text.push_back(c + CH_CTRL_OFS);
    end else if (nonprint_on && c == CH_DEL) begin
      text.push_back(CH_CARET); text.push_back(CH_QMARK);
    end else if (nonprint_on && c >= CH_META_LO && c < CH_META_HI) begin
      text.push_back(CH_M); text.push_back(CH_DASH);
      text.push_back(CH_CARET); text.push_back(c - CH_CTRL_OFS);
    end else if (nonprint_on && c == CH_FF) begin
      text.push_back(CH_M); text.push_back(CH_DASH);
      text.push_back(CH_CARET); text.push_back(CH_QMARK);
    end else begin
      text.push_back(c);
    end

    foreach (text[i]) begin
      beat.out_byte    = text[i];
      beat.last_of_run = (i == text.size() - 1);
      owed_beats.push_back(beat);
    end

    if (c == CH_NL) begin
      if (nl_run < 2'd2) nl_run = nl_run + 2'd1;
    end else begin
      nl_run = 2'd0;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      num_mode    = '0;
      squeeze     = 1'b0;
      ends_on     = 1'b0;
      tabs_on     = 1'b0;
      nonprint_on = 1'b0;
      line_no     = 1;
      nl_run      = 2'd1;
      owed_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_NUMBER_MODE:      num_mode    = cfg_wdata;
          REG_SQUEEZE_BLANK:    squeeze     = cfg_wdata[0];
          REG_SHOW_ENDS:        ends_on     = cfg_wdata[0];
          REG_SHOW_TABS:        tabs_on     = cfg_wdata[0];
          REG_SHOW_NONPRINTING: nonprint_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_beats.size() == 0) begin
          $error("output beat %02h arrived with no beat expected", out_beat.out_byte);
          fail_tally++;
        end else begin
          want = owed_beats.pop_front();
          if (out_beat.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_beat.out_byte);
            fail_tally++;
          end
          if (out_beat.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b",
                   want.last_of_run, out_beat.last_of_run);
            fail_tally++;
          end
        end
      end
      if (in_valid && in_ready) format_byte(in_beat.data_byte, in_beat.file_start);
    end
    mismatches <= fail_tally;
    beats_owed <= owed_beats.size();
  end

endmodule

// ===== tb/text_stream_line_number_formatter_tb.sv =====
// ----------------------------------------------------------------------------
// text_stream_line_number_formatter_tb
// Drives text bytes with random gaps and option settings into the line
// number formatter, stalls the output side at random, and reports the
// verdict from the checker that predicts and compares every output beat.
// ----------------------------------------------------------------------------
module text_stream_line_number_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tslnf_pkg::*;

  localparam int NUMBER_DIGITS  = 7;
  // Cycles the receiver refuses beats in its long hold-off.
  localparam int HOLD_CYCLES    = 400;
  // Cycles allowed after the last owed beat before options change or the
  // run ends.
  localparam int SETTLE_CYCLES  = 20;
  // Cycles in a row with no beat accepted on either channel.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 15;
  localparam int RANDOM_PHASES  = 8;

  // Numbering modes the package does not name.
  localparam logic [1:0] NUM_OFF   = 2'd0;
  localparam logic [1:0] NUM_THREE = 2'd3;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_beat;
  logic                out_valid;
  logic                out_ready;
  out_t                out_beat;
  int                  mismatches;
  int                  beats_owed;

  // Shared knobs: how often both sides idle, and a request for the long
  // receiver hold-off.
  int   gap_style = 0;
  logic hold_rx   = 1'b0;
  int   items_sent = 0;
  int   quiet_cycles = 0;

  text_stream_line_number_formatter #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_beat (out_beat)
  );

  tslnf_output_checker #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .mismatches(mismatches),
    .beats_owed(beats_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog ends a run that has hung: it counts cycles in which no beat
  // moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Gap length for either side. Style zero gives back-to-back traffic, the
  // others mostly short gaps with an occasional long one.
  function automatic int gap_len();
    int r;
    if (gap_style == 0) return 0;
    r = $urandom_range(0, 99);
    if (gap_style == 1) begin
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
    end
    if (r < 30) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  // The receiver makes exactly one assignment to out_ready at each clock
  // edge it wakes on, so a ready that stays high is never lowered and raised
  // again in the same step.
  initial begin
    int k;
    out_ready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (hold_rx) begin
        // Long hold-off while the sender keeps offering beats, so the block
        // fills up and drops in_ready.
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        k = gap_len();
        if (k > 0) begin
          out_ready <= 1'b0;
          repeat (k) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one input beat after a random gap and returns at the edge where
  // it is accepted. Valid stays high and the payload holds until then.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int k;
    k = gap_len();
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_beat.data_byte  <= b;
    in_beat.file_start <= fs;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Writes all five option registers on consecutive edges. Only called with
  // the block idle.
  task automatic write_options(input logic [1:0] mode, input logic sq, input logic se,
                               input logic st, input logic np);
    cfg_we <= 1'b1; cfg_addr <= REG_NUMBER_MODE;      cfg_wdata <= mode;
    @(posedge clk);
    cfg_addr <= REG_SQUEEZE_BLANK;    cfg_wdata <= {1'b0, sq};
    @(posedge clk);
    cfg_addr <= REG_SHOW_ENDS;        cfg_wdata <= {1'b0, se};
    @(posedge clk);
    cfg_addr <= REG_SHOW_TABS;        cfg_wdata <= {1'b0, st};
    @(posedge clk);
    cfg_addr <= REG_SHOW_NONPRINTING; cfg_wdata <= {1'b0, np};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering and waits until every owed beat has come out, then lets
  // the block settle. The first edge lets the checker count the last byte.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random chunk of text. Most chunks are ordinary lines so that the
  // numbering and newline logic see realistic traffic; the rest are runs of
  // blank lines and raw noise bytes.
  task automatic send_random_chunk();
    int         r;
    int         len;
    logic       fs;
    logic [7:0] c;
    r  = $urandom_range(0, 99);
    fs = ($urandom_range(0, 14) == 0);
    if (r < 65) begin
      len = $urandom_range(0, 8);
      repeat (len) begin
        c = ($urandom_range(0, 7) == 0) ? CH_TAB : 8'($urandom_range(32, 126));
        send_byte(c, fs);
        fs = 1'b0;
      end
      send_byte(CH_NL, fs);
    end else if (r < 82) begin
      len = $urandom_range(2, 4);
      repeat (len) begin
        send_byte(CH_NL, fs);
        fs = 1'b0;
      end
    end else begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        send_byte(8'($urandom), fs);
        fs = 1'b0;
      end
    end
  endtask

  initial begin
    int start;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset options: everything passes raw, including a tab, a newline and
    // byte 0xFF.
    gap_style = 1;
    send_byte(8'h78, 1'b1);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_FF, 1'b0);
    drain();

    // Every option on with all lines numbered. The newline run squeezes the
    // third and fourth newline away, and every escape class plus the edges of
    // the pass-through range of high bytes go by. The last byte restarts a
    // file on a newline while the run is full, so it must not be dropped.
    write_options(NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
    send_byte(8'h41, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(CH_DEL, 1'b0);
    send_byte(CH_META_LO, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(CH_META_HI, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(CH_FF, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b1);
    drain();

    // Non-blank numbering with only non-printing shown: a tab and a newline
    // still pass raw, and blank lines get no number.
    write_options(NUM_NONBLANK, 1'b0, 1'b0, 1'b0, 1'b1);
    send_byte(8'h62, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_NL, 1'b0);
    drain();

    // Mode three behaves like no numbering at all.
    write_options(NUM_THREE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'h63, 1'b1);
    send_byte(CH_NL, 1'b0);
    drain();

    // Random phases. The first two pin the option extremes, the rest draw
    // options at random. Phase two runs without any idling and phase three
    // carries the long receiver hold-off. Each phase ends with the sender
    // pausing until every owed beat has arrived.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        write_options(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
      end else if (p == 1) begin
        write_options(NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1);
      end else begin
        write_options(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom));
      end
      gap_style = (p == 2) ? 0 : $urandom_range(0, 2);
      if (p == 3) hold_rx = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_chunk();
      drain();
    end

    if (mismatches == 0 && beats_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
